// ===== hw/rtl/kdll_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kdll_pkg: shared types and constants of the keyed linked list
// Key width, opcode names and the request bundle for one link table.
// ----------------------------------------------------------------------------
package kdll_pkg;

  localparam int KeyW        = 7;
  localparam int MaxKeysDef  = 64;

  typedef enum logic [1:0] {
    OP_START   = 2'd0,
    OP_INSERT  = 2'd1,
    OP_REMOVE  = 2'd2,
    OP_READOUT = 2'd3
  } op_e;

  // one read and one write on a link table in a cycle
  typedef struct packed {
    logic            rd_en;
    logic [KeyW-1:0] rd_addr;
    logic            wr_en;
    logic [KeyW-1:0] wr_addr;
    logic [KeyW-1:0] wr_data;
  } link_req_t;

endpackage

// ===== hw/rtl/kdll_link_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kdll_link_mem: one link table
// Memory indexed by key with registered read data; per-entry valid bits make
// entries never written since reset read as zero.
// ----------------------------------------------------------------------------
module kdll_link_mem #(
  parameter int MAX_KEYS = kdll_pkg::MaxKeysDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  kdll_pkg::link_req_t      req_i,
  output logic [kdll_pkg::KeyW-1:0] rdata_o
);

  localparam int Depth = MAX_KEYS + 1;
  localparam int AddrW = $clog2(Depth);

  logic [kdll_pkg::KeyW-1:0] mem [Depth];
  logic [Depth-1:0]          vld_q;
  logic [kdll_pkg::KeyW-1:0] rdata_q;
  logic                      rvld_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[req_i.wr_addr[AddrW-1:0]] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rdata_q <= mem[req_i.rd_addr[AddrW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (req_i.wr_en) begin
        vld_q[req_i.wr_addr[AddrW-1:0]] <= 1'b1;
      end
      if (req_i.rd_en) begin
        rvld_q <= vld_q[req_i.rd_addr[AddrW-1:0]];
      end
    end
  end

  // unwritten entries read as "no link"
  assign rdata_o = rvld_q ? rdata_q : '0;

endmodule

// ===== hw/rtl/keyed_doubly_linked_list.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_doubly_linked_list: ordered list of distinct keys with link tables
// Start, insert-after, remove and readout requests on a doubly linked list.
// ----------------------------------------------------------------------------
// Keys 1..MAX_KEYS live in two link tables (successor and predecessor, each a
// memory indexed by key with one read and one write port) plus a head register;
// key 0 means "none". A start request is done in the accept state. Insert and
// remove each pass through the accept state, a read of the links of key_a, then
// dependent table writes in the LINK and FIX or CLR states. A readout walk
// issues one successor read per cycle while the output register is free, on
// the single read port of the successor table; each element shows on the
// output the cycle after it is walked, and the walk stalls while the output
// register is full. An empty list emits nothing and the sequencer stays
// idle. Tables clear at reset through per-entry valid bits, so there is no
// clearing pass. Requests are taken only while the sequencer is idle; a
// finished element may still be waiting in the output register when the
// next request is taken.
// ----------------------------------------------------------------------------
module keyed_doubly_linked_list #(
  parameter int MAX_KEYS = kdll_pkg::MaxKeysDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request side
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,   // [6:0] key_a, [13:7] key_b, [15:14] zero
  input  logic [1:0]  s_axis_tuser_i,   // [1:0] operation
  // element side
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,   // [6:0] element, [7] zero
  output logic        m_axis_tlast_o    // last element of the readout
);

  localparam int KeyW = kdll_pkg::KeyW;
  localparam int CntW = (MAX_KEYS > 2) ? $clog2(MAX_KEYS) : 1;

  // sequencer states, one-hot
  typedef enum logic [7:0] {
    ST_IDLE     = 8'b0000_0001,
    ST_INS_RD   = 8'b0000_0010,
    ST_INS_LINK = 8'b0000_0100,
    ST_INS_FIX  = 8'b0000_1000,
    ST_REM_RD   = 8'b0001_0000,
    ST_REM_LINK = 8'b0010_0000,
    ST_REM_CLR  = 8'b0100_0000,
    ST_WALK     = 8'b1000_0000
  } state_e;

  state_e              state_q, state_d;
  logic [KeyW-1:0]     head_q, head_d;
  logic [KeyW-1:0]     key_a_q, key_b_q;
  logic [KeyW-1:0]     pos_q, pos_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic                out_valid_q, out_valid_d;
  logic [KeyW-1:0]     elem_q, elem_d;
  logic                last_q, last_d;

  kdll_pkg::link_req_t next_req, prev_req;
  logic [KeyW-1:0]     next_rdata, prev_rdata;

  kdll_pkg::op_e       op_in;
  logic [KeyW-1:0]     key_a_in, key_b_in;
  logic                req_take;
  logic                out_free;
  logic                walk_last;
  logic                a_ok, b_ok;

  assign op_in    = kdll_pkg::op_e'(s_axis_tuser_i);
  assign key_a_in = s_axis_tdata_i[6:0];
  assign key_b_in = s_axis_tdata_i[13:7];

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign req_take        = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !out_valid_q || m_axis_tready_i;

  assign a_ok = (key_a_in != '0) && (key_a_in <= KeyW'(MAX_KEYS));
  assign b_ok = (key_b_in != '0) && (key_b_in <= KeyW'(MAX_KEYS));

  // end the walk on a null successor or once MAX_KEYS elements went out
  assign walk_last = (next_rdata == '0) || (cnt_q == CntW'(MAX_KEYS - 1));

  kdll_link_mem #(.MAX_KEYS(MAX_KEYS)) u_next (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (next_req),
    .rdata_o(next_rdata)
  );

  kdll_link_mem #(.MAX_KEYS(MAX_KEYS)) u_prev (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (prev_req),
    .rdata_o(prev_rdata)
  );

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    pos_d       = pos_q;
    cnt_d       = cnt_q;
    elem_d      = elem_q;
    last_d      = last_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    next_req    = '0;
    prev_req    = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (req_take) begin
          case (op_in)
            kdll_pkg::OP_START: begin
              // out-of-range keys leave the head alone
              if (key_a_in <= KeyW'(MAX_KEYS)) begin
                head_d = key_a_in;
              end
            end
            kdll_pkg::OP_INSERT: begin
              if (a_ok && b_ok && (key_a_in != key_b_in)) begin
                state_d = ST_INS_RD;
              end
            end
            kdll_pkg::OP_REMOVE: begin
              if (a_ok) begin
                state_d = ST_REM_RD;
              end
            end
            default: begin
              // readout: fetch the successor of the head
              if (head_q != '0) begin
                next_req.rd_en   = 1'b1;
                next_req.rd_addr = head_q;
                pos_d            = head_q;
                cnt_d            = '0;
                state_d          = ST_WALK;
              end
            end
          endcase
        end
      end

      ST_INS_RD: begin
        // prev[b] = a, fetch next[a]
        next_req.rd_en   = 1'b1;
        next_req.rd_addr = key_a_q;
        prev_req.wr_en   = 1'b1;
        prev_req.wr_addr = key_b_q;
        prev_req.wr_data = key_a_q;
        state_d          = ST_INS_LINK;
      end

      ST_INS_LINK: begin
        if (next_rdata != '0) begin
          next_req.wr_en   = 1'b1;
          next_req.wr_addr = key_b_q;
          next_req.wr_data = next_rdata;
          prev_req.wr_en   = 1'b1;
          prev_req.wr_addr = next_rdata;
          prev_req.wr_data = key_b_q;
        end
        state_d = ST_INS_FIX;
      end

      ST_INS_FIX: begin
        next_req.wr_en   = 1'b1;
        next_req.wr_addr = key_a_q;
        next_req.wr_data = key_b_q;
        state_d          = ST_IDLE;
      end

      ST_REM_RD: begin
        next_req.rd_en   = 1'b1;
        next_req.rd_addr = key_a_q;
        prev_req.rd_en   = 1'b1;
        prev_req.rd_addr = key_a_q;
        state_d          = ST_REM_LINK;
      end

      ST_REM_LINK: begin
        // repair the neighbours; a lone element keeps the head
        if (prev_rdata != '0) begin
          next_req.wr_en   = 1'b1;
          next_req.wr_addr = prev_rdata;
          next_req.wr_data = next_rdata;
        end
        if (next_rdata != '0) begin
          prev_req.wr_en   = 1'b1;
          prev_req.wr_addr = next_rdata;
          prev_req.wr_data = prev_rdata;
          if (prev_rdata == '0) begin
            head_d = next_rdata;
          end
        end
        state_d = ST_REM_CLR;
      end

      ST_REM_CLR: begin
        next_req.wr_en   = 1'b1;
        next_req.wr_addr = key_a_q;
        prev_req.wr_en   = 1'b1;
        prev_req.wr_addr = key_a_q;
        state_d          = ST_IDLE;
      end

      ST_WALK: begin
        // emit the current key and fetch the next one in the same cycle
        if (out_free) begin
          out_valid_d = 1'b1;
          elem_d      = pos_q;
          last_d      = walk_last;
          if (walk_last) begin
            state_d = ST_IDLE;
          end else begin
            next_req.rd_en   = 1'b1;
            next_req.rd_addr = next_rdata;
            pos_d            = next_rdata;
            cnt_d            = cnt_q + 1'b1;
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= '0;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
    end
  end

  // hold the request keys and walk position
  always_ff @(posedge clk_i) begin
    if (req_take) begin
      key_a_q <= key_a_in;
      key_b_q <= key_b_in;
    end
    pos_q  <= pos_d;
    elem_q <= elem_d;
    last_q <= last_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {1'b0, elem_q};
  assign m_axis_tlast_o  = last_q;

  // -------------------------------------------------------------------------
  // Assertions
  // -------------------------------------------------------------------------
  a_head_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_q <= KeyW'(MAX_KEYS))
    else $error("head key beyond key range");

  a_elem_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[6:0] != '0))
    else $error("null key emitted");

  // an element of an earlier run may still wait in the output register
  a_empty_readout: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_take && (op_in == kdll_pkg::OP_READOUT) && (head_q == '0))
      |=> (state_q == ST_IDLE))
    else $error("readout of empty list started a walk");

  a_walk_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_WALK) && out_free && walk_last)
      |=> (state_q == ST_IDLE) && m_axis_tlast_o && m_axis_tvalid_o)
    else $error("walk did not end after its last element");

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for keyed_doubly_linked_list
// Drives start, insert, remove and readout requests through the request
// stream, mirrors the link tables in a scoreboard and checks every element
// of each readout run, key and last flag, in order.
// ----------------------------------------------------------------------------
module tb;
  import kdll_pkg::*;

  localparam int MaxKeys     = MaxKeysDef;
  localparam int RandomItems = 300;
  localparam int CycleLimit  = 1000000;

  typedef struct packed {
    logic [KeyW-1:0] key;
    logic            last;
  } element_t;

  typedef enum int {
    STALL_NONE,
    STALL_RANDOM,
    STALL_PERIODIC,
    STALL_LONG
  } stall_mode_e;

  // Mirror of the list state; predicts each readout run.
  class list_scoreboard;
    logic [KeyW-1:0] succ [0:MaxKeys];
    logic [KeyW-1:0] pred [0:MaxKeys];
    logic [KeyW-1:0] head;
    element_t        pending [$];
    int unsigned     mismatches, checked, requests, readouts, longest;

    function new();
      foreach (succ[k]) begin
        succ[k] = '0;
        pred[k] = '0;
      end
      head = '0;
    endfunction

    function bit key_valid(logic [KeyW-1:0] k);
      return k >= 1 && k <= MaxKeys;
    endfunction

    function logic [KeyW-1:0] succ_of(logic [KeyW-1:0] k);
      return (k <= MaxKeys) ? succ[k] : '0;
    endfunction

    function void set_succ(logic [KeyW-1:0] k, logic [KeyW-1:0] v);
      if (k <= MaxKeys) succ[k] = v;
    endfunction

    function void set_pred(logic [KeyW-1:0] k, logic [KeyW-1:0] v);
      if (k <= MaxKeys) pred[k] = v;
    endfunction

    // Walk from the head; stop at a null link or after MaxKeys elements.
    function void walk(ref logic [KeyW-1:0] order[$]);
      logic [KeyW-1:0] pos;
      order.delete();
      pos = head;
      if (pos == 0 || pos > MaxKeys) return;
      forever begin
        order.push_back(pos);
        if (succ_of(pos) == 0 || order.size() >= MaxKeys) break;
        pos = succ_of(pos);
      end
    endfunction

    function void note_request(op_e op, logic [KeyW-1:0] ka, logic [KeyW-1:0] kb);
      logic [KeyW-1:0] x_next, x_prev;
      logic [KeyW-1:0] order [$];
      element_t        e;
      requests++;
      case (op)
        OP_START: begin
          if (ka <= MaxKeys) head = ka;
        end
        OP_INSERT: begin
          if (key_valid(ka) && key_valid(kb) && ka != kb) begin
            set_pred(kb, ka);
            x_next = succ_of(ka);
            if (x_next != 0) begin
              set_succ(kb, x_next);
              set_pred(x_next, kb);
            end
            set_succ(ka, kb);
          end
        end
        OP_REMOVE: begin
          if (key_valid(ka)) begin
            x_prev = pred[ka];
            x_next = succ[ka];
            if (x_prev != 0 && x_next != 0) begin
              set_succ(x_prev, x_next);
              set_pred(x_next, x_prev);
            end else if (x_prev != 0) begin
              set_succ(x_prev, '0);
            end else if (x_next != 0) begin
              set_pred(x_next, '0);
              head = x_next;
            end
            // the only element leaves the head where it is
            set_pred(ka, '0);
            set_succ(ka, '0);
          end
        end
        default: begin
          readouts++;
          walk(order);
          if (order.size() > longest) longest = order.size();
          foreach (order[i]) begin
            e.key  = order[i];
            e.last = (i == order.size() - 1);
            pending.push_back(e);
          end
        end
      endcase
    endfunction

    function void check_element(logic [KeyW-1:0] key, logic last, longint stamp);
      element_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected element: expected none, actual key %0d last %0b",
                 stamp, key, last);
        mismatches++;
        return;
      end
      want = pending.pop_front();
      checked++;
      if (want.key !== key) begin
        $display("%0t: element key mismatch: expected %0d, actual %0d",
                 stamp, want.key, key);
        mismatches++;
      end
      if (want.last !== last) begin
        $display("%0t: last flag mismatch on key %0d: expected %0b, actual %0b",
                 stamp, want.key, want.last, last);
        mismatches++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [15:0] s_axis_tdata_i;
  logic [1:0]  s_axis_tuser_i;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [7:0]  m_axis_tdata_o;
  logic        m_axis_tlast_o;

  list_scoreboard sb = new();
  int unsigned    cycle_count = 0;

  keyed_doubly_linked_list #(
    .MAX_KEYS (MaxKeys)
  ) DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Watchdog: end the run if it hangs.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  // Check every accepted element.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i)
      sb.check_element(m_axis_tdata_o[KeyW-1:0], m_axis_tlast_o, $time);
  end

  // Receiver back-pressure: switch between stall patterns every so often.
  initial begin
    stall_mode_e mode;
    int          span;
    int          tick;
    tick = 0;
    m_axis_tready_i = 1'b0;
    forever begin
      mode = stall_mode_e'($urandom_range(STALL_NONE, STALL_LONG));
      span = $urandom_range(20, 150);
      repeat (span) begin
        @(negedge clk_i);
        tick++;
        case (mode)
          STALL_NONE:     m_axis_tready_i = 1'b1;
          STALL_RANDOM:   m_axis_tready_i = ($urandom_range(0, 9) < 7);
          STALL_PERIODIC: m_axis_tready_i = (tick % 3 == 0);
          default:        m_axis_tready_i = (tick % 16) >= 12;
        endcase
      end
    end
  end

  // Present one request at the falling edge and hold until it is accepted.
  task automatic send_request(op_e op, logic [KeyW-1:0] ka, logic [KeyW-1:0] kb);
    @(negedge clk_i);
    s_axis_tvalid_i = 1'b1;
    s_axis_tuser_i  = op;
    s_axis_tdata_i  = {2'b00, kb, ka};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    sb.note_request(op, ka, kb);
  endtask

  // Drop valid for a number of cycles, with junk on the data lines.
  task automatic idle_sender(int cycles);
    repeat (cycles) begin
      @(negedge clk_i);
      s_axis_tvalid_i = 1'b0;
      s_axis_tuser_i  = 2'($urandom_range(0, 3));
      s_axis_tdata_i  = {2'b00, 14'($urandom)};
    end
  endtask

  // Mostly well-formed list edits on the current state, with some noise.
  task automatic pick_request(output op_e op, output logic [KeyW-1:0] ka,
                              output logic [KeyW-1:0] kb, output bit noise);
    logic [KeyW-1:0] order [$];
    logic [KeyW-1:0] free_keys [$];
    logic [KeyW-1:0] leaked [$];
    bit              on_list [0:MaxKeys];
    int              r;
    r     = $urandom_range(0, 99);
    noise = 1'b0;
    kb    = 7'($urandom_range(0, 127));
    sb.walk(order);
    foreach (on_list[k]) on_list[k] = 1'b0;
    foreach (order[i]) on_list[order[i]] = 1'b1;
    for (int k = 1; k <= MaxKeys; k++) begin
      if (!on_list[k] && sb.succ[k] == 0 && sb.pred[k] == 0 && k != sb.head)
        free_keys.push_back(7'(k));
      else if (!on_list[k] && (sb.succ[k] != 0 || sb.pred[k] != 0))
        leaked.push_back(7'(k));
    end
    if (r < 10) begin
      noise = 1'b1;
      op    = op_e'($urandom_range(0, 3));
      ka    = 7'($urandom_range(0, 127));
    end else if (order.size() == 0) begin
      op = OP_START;
      ka = (free_keys.size() != 0) ? free_keys[$urandom_range(0, free_keys.size() - 1)]
                                   : 7'($urandom_range(1, MaxKeys));
    end else if (r < 48 && free_keys.size() != 0) begin
      op = OP_INSERT;
      ka = order[$urandom_range(0, order.size() - 1)];
      kb = free_keys[$urandom_range(0, free_keys.size() - 1)];
    end else if (r < 66) begin
      op = OP_REMOVE;
      ka = order[$urandom_range(0, order.size() - 1)];
    end else if (r < 71) begin
      // tidy up keys stranded off the list, or move the head along it
      if (leaked.size() != 0) begin
        op = OP_REMOVE;
        ka = leaked[$urandom_range(0, leaked.size() - 1)];
      end else begin
        op = OP_START;
        ka = order[$urandom_range(0, order.size() - 1)];
      end
    end else begin
      op = OP_READOUT;
      ka = 7'($urandom_range(0, 127));
    end
  endtask

  initial begin
    op_e             op;
    logic [KeyW-1:0] ka, kb;
    bit              noise;
    int              effective;
    int              burst;

    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = OP_START;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    idle_sender(2);

    // Directed: empty readout, edges of the key range, all special cases.
    send_request(OP_READOUT, 7'd0,   7'd0);    // empty list
    send_request(OP_START,   7'd5,   7'd0);
    send_request(OP_READOUT, 7'd0,   7'd0);
    send_request(OP_INSERT,  7'd5,   7'd9);
    send_request(OP_INSERT,  7'd5,   7'd64);   // top key, mid-list insert
    send_request(OP_INSERT,  7'd9,   7'd1);
    send_request(OP_INSERT,  7'd0,   7'd3);    // zero anchor
    send_request(OP_INSERT,  7'd3,   7'd0);    // zero new key
    send_request(OP_INSERT,  7'd9,   7'd9);    // key after itself
    send_request(OP_INSERT,  7'd127, 7'd127);  // out of range
    send_request(OP_INSERT,  7'd5,   7'd65);   // out of range
    send_request(OP_READOUT, 7'd127, 7'd127);
    send_request(OP_REMOVE,  7'd0,   7'd0);
    send_request(OP_REMOVE,  7'd127, 7'd0);
    send_request(OP_REMOVE,  7'd64,  7'd0);    // middle
    send_request(OP_REMOVE,  7'd5,   7'd0);    // head
    send_request(OP_REMOVE,  7'd1,   7'd0);    // tail
    send_request(OP_REMOVE,  7'd9,   7'd0);    // only element
    send_request(OP_READOUT, 7'd0,   7'd0);
    send_request(OP_START,   7'd127, 7'd0);    // ignored
    send_request(OP_START,   7'd0,   7'd0);
    send_request(OP_READOUT, 7'd0,   7'd0);
    send_request(OP_START,   7'd1,   7'd0);
    send_request(OP_INSERT,  7'd1,   7'd2);
    send_request(OP_INSERT,  7'd2,   7'd1);    // relink a present key: cycle
    send_request(OP_READOUT, 7'd0,   7'd0);    // runaway walk
    send_request(OP_REMOVE,  7'd3,   7'd0);    // key not on the list
    send_request(OP_REMOVE,  7'd1,   7'd0);

    // Random: bursts of requests with gaps of random length between them.
    effective = 0;
    while (effective < RandomItems) begin
      burst = $urandom_range(1, 8);
      repeat (burst) begin
        pick_request(op, ka, kb, noise);
        send_request(op, ka, kb);
        if (!noise) effective++;
      end
      if ($urandom_range(0, 3) != 0) idle_sender($urandom_range(1, 12));
    end
    idle_sender(1);

    // Drain outstanding elements, then allow time for any stray ones.
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);

    $display("Ran %0d requests, %0d readouts (longest run %0d elements)",
             sb.requests, sb.readouts, sb.longest);
    $display("Checked %0d elements, %0d mismatches", sb.checked, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
